FILE: rtl/crv_pkg.sv
// Shared types, constants and decode functions for the command request validator.
// No dependencies; imported by crv_ram users, crv_parse and the top level.
package crv_pkg;

  localparam int MAX_ID_LEN = 64;
  localparam int ID_AW      = $clog2(MAX_ID_LEN);
  localparam int CNT_W      = $clog2(MAX_ID_LEN + 3);
  localparam int STEP_W     = 6;
  localparam int PROG_LEN   = 48;

  localparam logic [CNT_W-1:0]  MAX_ID_CNT = CNT_W'(MAX_ID_LEN);
  localparam logic [STEP_W-1:0] PROG_LAST  = STEP_W'(PROG_LEN - 1);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_VERSION   = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_MISMATCH  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_VERSION = 4'd0,
    OP_CMDID   = 4'd1,
    OP_TAG     = 4'd2,
    OP_ID      = 4'd3,
    OP_SKIP4   = 4'd4,
    OP_SKIP8   = 4'd5,
    OP_ENUM1   = 4'd6,
    OP_ENUM2   = 4'd7,
    OP_FLAG    = 4'd8,
    OP_END     = 4'd9
  } op_t;

  typedef struct packed {
    logic       request;
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] tag;
  } result_t;

  typedef struct packed {
    logic             en;
    logic [ID_AW-1:0] addr;
    logic [7:0]       data;
  } ram_wr_t;

  function automatic op_t prog_op(input logic [STEP_W-1:0] step);
    op_t op;
    unique case (step)
      6'd0:                                          op = OP_VERSION;
      6'd1:                                          op = OP_CMDID;
      6'd2:                                          op = OP_TAG;
      6'd3, 6'd4, 6'd5, 6'd6, 6'd14, 6'd16, 6'd17, 6'd18, 6'd19, 6'd21,
      6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd38,
      6'd41, 6'd42, 6'd43, 6'd44:                    op = OP_ID;
      6'd7, 6'd23:                                   op = OP_ENUM1;
      6'd9, 6'd11, 6'd25, 6'd27:                     op = OP_ENUM2;
      6'd8, 6'd10, 6'd12, 6'd24, 6'd26, 6'd28:       op = OP_SKIP8;
      6'd15, 6'd22, 6'd39, 6'd46:                    op = OP_SKIP4;
      6'd40:                                         op = OP_FLAG;
      default:                                       op = OP_END;
    endcase
    return op;
  endfunction

  function automatic logic [STEP_W-1:0] tag_start(input logic [2:0] tag);
    logic [STEP_W-1:0] s;
    unique case (tag)
      3'd1:    s = 6'd3;
      3'd2:    s = 6'd14;
      3'd3:    s = 6'd21;
      3'd4:    s = 6'd38;
      3'd5:    s = 6'd46;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
           (b >= 8'h30 && b <= 8'h39);
  endfunction

  function automatic logic is_id_rest(input logic [7:0] b);
    return is_alnum(b) || b == 8'h2E || b == 8'h5F || b == 8'h3A || b == 8'h2D;
  endfunction

endpackage

FILE: rtl/crv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; read returns the old contents on a same-address write.
module crv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/crv_parse.sv
// Per-byte parser state and next-state logic for request and expected-identifier bytes.
// Depends on crv_pkg; drives the expected-identifier RAM held in the top level.
module crv_parse import crv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  item_t             item,
  input  logic [7:0]        format_version,
  input  logic [7:0]        rd_data,
  output logic [ID_AW-1:0]  rd_addr,
  output ram_wr_t           wr,
  output result_t           res
);

  logic [STEP_W-1:0] parse_step, parse_step_next;
  logic [CNT_W-1:0]  fbc, fbc_next;
  logic [CNT_W-1:0]  fid_len, fid_len_next;
  logic              id_differs, id_differs_next;
  status_t           error_code, error_code_next;
  logic              error_seen, error_seen_next;
  logic [2:0]        seen_tag, seen_tag_next;
  logic [CNT_W-1:0]  id_count, id_count_next;
  logic              load_open, load_open_next;
  logic              byp_hit;
  logic [7:0]        byp_data;

  always_comb begin
    logic [CNT_W-1:0] cnt_base;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] rd_idx;
    logic [7:0]       ref_byte;
    logic             id_bad;
    logic             id_done;
    logic             cmp;
    logic             do_adv;
    op_t              op;

    parse_step_next = parse_step;
    fbc_next        = fbc;
    fid_len_next    = fid_len;
    id_differs_next = id_differs;
    error_code_next = error_code;
    error_seen_next = error_seen;
    seen_tag_next   = seen_tag;
    id_count_next   = id_count;
    load_open_next  = load_open;
    wr              = '0;
    res             = '{status: ST_OK, tag: 3'd0};
    cnt_base        = '0;
    idx             = fbc - CNT_W'(2);
    ref_byte        = byp_hit ? byp_data : rd_data;
    id_bad          = 1'b0;
    id_done         = 1'b0;
    do_adv          = 1'b0;
    op              = prog_op(parse_step);
    cmp             = (op == OP_CMDID);

    if (step && !item.request) begin
      cnt_base       = load_open ? id_count : '0;
      load_open_next = !item.last;
      if (cnt_base < MAX_ID_CNT) begin
        wr = '{en: 1'b1, addr: cnt_base[ID_AW-1:0], data: item.data};
      end
      id_count_next = (cnt_base <= MAX_ID_CNT) ? cnt_base + CNT_W'(1) : cnt_base;
    end else if (step) begin
      if (!error_seen) begin
        unique case (op)
          OP_VERSION: begin
            if (item.data != format_version) begin
              error_seen_next = 1'b1;
              error_code_next = ST_VERSION;
            end else begin
              do_adv = 1'b1;
            end
          end
          OP_CMDID, OP_ID: begin
            if (fbc == '0) begin
              fid_len_next = (item.data != 8'd0 && item.data <= 8'(MAX_ID_LEN)) ?
                             item.data[CNT_W-1:0] : '0;
              fbc_next     = CNT_W'(1);
            end else if (fbc == CNT_W'(1)) begin
              if (item.data != 8'd0 || fid_len == '0) begin
                id_bad = 1'b1;
              end else begin
                if (cmp) begin
                  id_differs_next = (fid_len != id_count);
                end
                fbc_next = CNT_W'(2);
              end
            end else begin
              if ((idx == '0) ? !is_alnum(item.data) : !is_id_rest(item.data)) begin
                id_bad = 1'b1;
              end else begin
                if (cmp && !id_differs && idx < id_count && idx < MAX_ID_CNT &&
                    ref_byte != item.data) begin
                  id_differs_next = 1'b1;
                end
                fbc_next = fbc + CNT_W'(1);
                id_done  = (fbc - CNT_W'(1)) >= fid_len;
              end
            end
            if (id_bad) begin
              error_seen_next = 1'b1;
              error_code_next = ST_MALFORMED;
            end else if (id_done) begin
              if (cmp && id_differs_next) begin
                error_seen_next = 1'b1;
                error_code_next = ST_MISMATCH;
              end else begin
                do_adv = 1'b1;
              end
            end
          end
          OP_TAG: begin
            if (item.data >= 8'd1 && item.data <= 8'd5) begin
              seen_tag_next   = item.data[2:0];
              parse_step_next = tag_start(item.data[2:0]);
              fbc_next        = '0;
              fid_len_next    = '0;
            end else begin
              error_seen_next = 1'b1;
              error_code_next = ST_MALFORMED;
            end
          end
          OP_SKIP4, OP_SKIP8: begin
            fbc_next = fbc + CNT_W'(1);
            do_adv   = fbc_next >= ((op == OP_SKIP4) ? CNT_W'(4) : CNT_W'(8));
          end
          OP_ENUM1, OP_ENUM2: begin
            if (item.data > ((op == OP_ENUM1) ? 8'd1 : 8'd2)) begin
              error_seen_next = 1'b1;
              error_code_next = ST_MALFORMED;
            end else begin
              do_adv = 1'b1;
            end
          end
          OP_FLAG: begin
            if (item.data > 8'd1) begin
              error_seen_next = 1'b1;
              error_code_next = ST_MALFORMED;
            end else begin
              do_adv = 1'b1;
            end
          end
          default: begin
            error_seen_next = 1'b1;
            error_code_next = ST_MALFORMED;
          end
        endcase
        if (do_adv) begin
          parse_step_next = parse_step + ((op == OP_FLAG && item.data == 8'd0) ?
                                          STEP_W'(5) : STEP_W'(1));
          fbc_next        = '0;
          fid_len_next    = '0;
        end
      end

      if (error_seen_next) begin
        res = '{status: error_code_next, tag: 3'd0};
      end else if (parse_step_next <= PROG_LAST && prog_op(parse_step_next) == OP_END) begin
        res = '{status: ST_OK, tag: seen_tag_next};
      end else begin
        res = '{status: ST_MALFORMED, tag: 3'd0};
      end

      if (item.last) begin
        parse_step_next = '0;
        fbc_next        = '0;
        fid_len_next    = '0;
        id_differs_next = 1'b0;
        error_code_next = ST_OK;
        error_seen_next = 1'b0;
        seen_tag_next   = 3'd0;
      end
    end

    rd_idx  = fbc_next - CNT_W'(2);
    rd_addr = rd_idx[ID_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_step <= '0;
      fbc        <= '0;
      fid_len    <= '0;
      id_differs <= 1'b0;
      error_code <= ST_OK;
      error_seen <= 1'b0;
      seen_tag   <= 3'd0;
      id_count   <= '0;
      load_open  <= 1'b0;
      byp_hit    <= 1'b0;
    end else begin
      parse_step <= parse_step_next;
      fbc        <= fbc_next;
      fid_len    <= fid_len_next;
      id_differs <= id_differs_next;
      error_code <= error_code_next;
      error_seen <= error_seen_next;
      seen_tag   <= seen_tag_next;
      id_count   <= id_count_next;
      load_open  <= load_open_next;
      byp_hit    <= wr.en && (wr.addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= wr.data;
  end

endmodule

FILE: rtl/command_request_validator_top.sv
// Command request validator top level: stream handshake, input and result registers.
// Depends on crv_pkg, crv_parse and crv_ram.
//
// Usage:
//   s_* carries one byte per transaction. s_tuser = 0 loads a byte of the expected
//   command identifier, s_tuser = 1 is a request byte; s_tlast ends the identifier
//   run or the request. A request's final byte yields one result transaction on
//   m_*; all other bytes yield none.
//   cfg_* writes the required format version byte; write it only while idle.
// Timing:
//   An accepted byte waits in the input register until the parser steps, is checked in
//   that step, and a final request byte's result is registered into m_tdata and m_tvalid.
//   One byte is taken every cycle unless a final request byte waits on a held result;
//   the single check stage and the registered expected-identifier RAM read set that rate.
// Reset:
//   rst clears the parser, sets the format version to 1 and the expected length to
//   zero; the identifier RAM is not cleared and its data is used only below the loaded length.
// Backpressure:
//   With m_tready low the result register holds; bytes that produce no result keep
//   flowing, and the final byte of the next request waits in the input register.
module command_request_validator_top import crv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,
  input  logic       s_tuser,   // [0] operation
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [1:0] status, [4:2] command_tag, [7:5] zero
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic             in_vld;
  item_t            in_item;
  logic             emits;
  logic             step;
  logic [7:0]       format_version;
  logic [ID_AW-1:0] rd_addr;
  logic [7:0]       rd_data;
  ram_wr_t          wr;
  result_t          res;

  assign emits     = in_item.request && in_item.last;
  assign step      = in_vld && (!emits || !m_tvalid || m_tready);
  assign s_tready  = !in_vld || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld         <= 1'b0;
      m_tvalid       <= 1'b0;
      format_version <= 8'd1;
    end else begin
      if (s_tready) begin
        in_vld <= s_tvalid;
      end
      if (step && emits) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        format_version <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= '{request: s_tuser, data: s_tdata, last: s_tlast};
    end
    if (step && emits) begin
      m_tdata <= {3'd0, res.tag, res.status};
    end
  end

  crv_parse u_parse (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .item           (in_item),
    .format_version (format_version),
    .rd_data        (rd_data),
    .rd_addr        (rd_addr),
    .wr             (wr),
    .res            (res)
  );

  crv_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ID_LEN)
  ) u_id_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (step && emits) |=> m_tvalid)
    else $error("result transaction not raised after final request byte");

  a_ok_has_tag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == ST_OK) |-> (m_tdata[4:2] != 3'd0))
    else $error("ok status without a command tag");

  a_err_no_tag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != ST_OK) |-> (m_tdata[4:2] == 3'd0))
    else $error("error status with a nonzero command tag");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !step) |=> (in_vld && $stable(in_item)))
    else $error("pending byte dropped or overwritten");
`endif

endmodule

FILE: sim/command_request_validator_top_test.sv
// Self-checking test for command_request_validator_top: loads expected identifiers,
// streams well-formed, faulty and random command requests, predicts each verdict.
// Depends on crv_pkg and the RTL top level; needs no files or arguments.
module command_request_validator_top_test;
  import crv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef logic [7:0] bytes_t[$];

  typedef enum {ID_MORE, ID_DONE, ID_BAD} id_scan_t;

  typedef enum {
    F_NONE,
    F_VERSION,
    F_CMD_MISMATCH_BYTE,
    F_CMD_MISMATCH_LEN,
    F_BAD_LEN,
    F_BAD_HEAD,
    F_BAD_TAIL,
    F_BAD_TAG,
    F_BAD_ENUM,
    F_BAD_FLAG,
    F_TRUNCATE,
    F_EXTRA,
    F_CORRUPT
  } fault_t;

  class request_scoreboard;
    logic [7:0] version;
    logic [7:0] id_store [64];
    logic [6:0] id_count;
    bit         load_open;
    op_t        plan [48];
    logic [5:0] step;
    logic [6:0] fcount;
    logic [7:0] len_low;
    logic [6:0] flen;
    bit         differs;
    bit         err_seen;
    bit         reversal;
    status_t    err_code;
    logic [2:0] tag;
    result_t    outcomes [$];
    int         errors;

    function new();
      plan = '{OP_VERSION, OP_CMDID, OP_TAG,
               OP_ID, OP_ID, OP_ID, OP_ID, OP_ENUM1, OP_SKIP8, OP_ENUM2, OP_SKIP8,
               OP_ENUM2, OP_SKIP8, OP_END,
               OP_ID, OP_SKIP4, OP_ID, OP_ID, OP_ID, OP_ID, OP_END,
               OP_ID, OP_SKIP4, OP_ENUM1, OP_SKIP8, OP_ENUM2, OP_SKIP8, OP_ENUM2,
               OP_SKIP8, OP_ID, OP_ID, OP_ID, OP_ID, OP_ID, OP_ID, OP_ID, OP_ID, OP_END,
               OP_ID, OP_SKIP4, OP_FLAG, OP_ID, OP_ID, OP_ID, OP_ID, OP_END,
               OP_SKIP4, OP_END};
      version   = 8'd1;
      id_count  = '0;
      load_open = 1'b0;
      errors    = 0;
      foreach (id_store[i]) id_store[i] = 8'h00;
      clear_request();
    endfunction

    static function bit head_ok(logic [7:0] b);
      return b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    static function bit tail_ok(logic [7:0] b);
      return head_ok(b) || (b inside {8'h2D, 8'h2E, 8'h3A, 8'h5F});
    endfunction

    function void clear_request();
      step     = '0;
      fcount   = '0;
      len_low  = '0;
      flen     = '0;
      differs  = 1'b0;
      err_seen = 1'b0;
      err_code = ST_OK;
      tag      = '0;
      reversal = 1'b0;
    endfunction

    function void flag_error(status_t code);
      err_seen = 1'b1;
      err_code = code;
    endfunction

    function void next_field();
      step++;
      fcount = '0;
      flen   = '0;
    endfunction

    function logic [5:0] body_entry(logic [2:0] t);
      case (t)
        3'd1:    return 6'd3;
        3'd2:    return 6'd14;
        3'd3:    return 6'd21;
        3'd4:    return 6'd38;
        default: return 6'd46;
      endcase
    endfunction

    function id_scan_t ident_byte(logic [7:0] b, bit compare);
      logic [15:0] len;
      logic [6:0]  idx;
      if (fcount == 0) begin
        len_low = b;
        fcount  = 7'd1;
        return ID_MORE;
      end
      if (fcount == 1) begin
        len = {b, len_low};
        if (len == 0 || len > MAX_ID_LEN) return ID_BAD;
        flen = len[6:0];
        if (compare) differs = (len != {9'd0, id_count});
        fcount = 7'd2;
        return ID_MORE;
      end
      idx = fcount - 7'd2;
      if (idx == 0 ? !head_ok(b) : !tail_ok(b)) return ID_BAD;
      if (compare && !differs && idx < id_count && idx < MAX_ID_LEN &&
          id_store[idx[5:0]] != b) differs = 1'b1;
      fcount++;
      return (idx + 1 >= flen) ? ID_DONE : ID_MORE;
    endfunction

    function void take_request_byte(logic [7:0] b);
      op_t      op;
      id_scan_t r;
      op = (step < PROG_LEN) ? plan[step] : OP_END;
      case (op)
        OP_VERSION: begin
          if (b != version) flag_error(ST_VERSION);
          else next_field();
        end
        OP_CMDID: begin
          r = ident_byte(b, 1'b1);
          if (r == ID_BAD) flag_error(ST_MALFORMED);
          else if (r == ID_DONE) begin
            if (differs) flag_error(ST_MISMATCH);
            else next_field();
          end
        end
        OP_TAG: begin
          if (b >= 8'd1 && b <= 8'd5) begin
            tag    = b[2:0];
            step   = body_entry(b[2:0]);
            fcount = '0;
            flen   = '0;
          end else begin
            flag_error(ST_MALFORMED);
          end
        end
        OP_ID: begin
          r = ident_byte(b, 1'b0);
          if (r == ID_BAD) flag_error(ST_MALFORMED);
          else if (r == ID_DONE) next_field();
        end
        OP_SKIP4, OP_SKIP8: begin
          fcount++;
          if (fcount >= (op == OP_SKIP4 ? 4 : 8)) next_field();
        end
        OP_ENUM1, OP_ENUM2: begin
          if (b > (op == OP_ENUM1 ? 1 : 2)) flag_error(ST_MALFORMED);
          else next_field();
        end
        OP_FLAG: begin
          if (b > 8'd1) begin
            flag_error(ST_MALFORMED);
          end else begin
            reversal = b[0];
            next_field();
            if (!reversal) step = step + 6'd4;
          end
        end
        default: flag_error(ST_MALFORMED);
      endcase
    endfunction

    function void note_byte(bit request, logic [7:0] b, bit last);
      result_t res;
      if (!request) begin
        if (!load_open) begin
          id_count  = '0;
          load_open = 1'b1;
        end
        if (id_count < MAX_ID_LEN) id_store[id_count[5:0]] = b;
        if (id_count <= MAX_ID_LEN) id_count++;
        if (last) load_open = 1'b0;
        return;
      end
      if (!err_seen) take_request_byte(b);
      if (!last) return;
      res.tag = 3'd0;
      if (err_seen) begin
        res.status = err_code;
      end else if (step < PROG_LEN && plan[step] == OP_END) begin
        res.status = ST_OK;
        res.tag    = tag;
      end else begin
        res.status = ST_MALFORMED;
      end
      outcomes.push_back(res);
      clear_request();
    endfunction

    function void check_result(logic [7:0] word);
      result_t want;
      if (outcomes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d tag %0d",
                 $time, word[1:0], word[4:2]);
        return;
      end
      want = outcomes.pop_front();
      if (word[1:0] != want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, word[1:0]);
      end
      if (word[4:2] != want.tag) begin
        errors++;
        $display("%0t: command_tag expected %0d actual %0d", $time, want.tag, word[4:2]);
      end
    endfunction

    function int pending();
      return outcomes.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       s_tuser;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  request_scoreboard sb = new();

  bytes_t     msg;
  bytes_t     cur_id;
  item_t      staged [$];
  logic [7:0] cur_version;
  bit         gaps_on;
  bit         stalls_on;
  bit         last_phase;
  fault_t     body_fault;
  bit         enum_fault;
  int         enum_seen;
  int         enum_pick;
  int         bytes_sent;
  int         requests_sent;
  int         cycles;

  command_request_validator_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (!rst) begin
      if (cfg_valid && cfg_ready) sb.version = cfg_data;
      if (s_tvalid && s_tready) sb.note_byte(s_tuser, s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  initial begin
    m_tready = 1'b0;
    wait (!rst);
    forever begin
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  function automatic logic [7:0] id_char(bit head);
    int k;
    k = $urandom_range(0, head ? 61 : 65);
    if (k < 10) return 8'(8'h30 + k);
    if (k < 36) return 8'(8'h41 + k - 10);
    if (k < 62) return 8'(8'h61 + k - 36);
    case (k)
      62:      return 8'h2E;
      63:      return 8'h5F;
      64:      return 8'h3A;
      default: return 8'h2D;
    endcase
  endfunction

  function automatic logic [7:0] bad_char(bit head);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (head ? request_scoreboard::head_ok(b) : request_scoreboard::tail_ok(b));
    return b;
  endfunction

  function automatic bytes_t rand_ident(int len);
    bytes_t q;
    for (int i = 0; i < len; i++) q.push_back(id_char(i == 0));
    return q;
  endfunction

  function automatic bytes_t pick_expected_id();
    bytes_t q;
    case ($urandom_range(0, 9))
      0: begin
        repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
      end
      1:       q = rand_ident(MAX_ID_LEN);
      2:       q = rand_ident($urandom_range(MAX_ID_LEN + 1, MAX_ID_LEN + 6));
      default: q = rand_ident($urandom_range(1, 10));
    endcase
    return q;
  endfunction

  function automatic int body_len();
    case ($urandom_range(0, 19))
      0:       return MAX_ID_LEN;
      1:       return $urandom_range(7, MAX_ID_LEN - 1);
      default: return $urandom_range(1, 5);
    endcase
  endfunction

  function automatic void push_ident(bytes_t id, fault_t f);
    int         v;
    int         pos;
    logic [7:0] c;
    if (f == F_BAD_LEN) begin
      case ($urandom_range(0, 2))
        0:       v = 0;
        1:       v = $urandom_range(MAX_ID_LEN + 1, 255);
        default: v = $urandom_range(256, 65535);
      endcase
      msg.push_back(v[7:0]);
      msg.push_back(v[15:8]);
      repeat ($urandom_range(0, 3)) msg.push_back(id_char(1'b0));
      return;
    end
    pos = (f == F_BAD_TAIL && id.size() > 1) ? $urandom_range(1, id.size() - 1) : 0;
    msg.push_back(8'(id.size()));
    msg.push_back(8'(id.size() >> 8));
    foreach (id[i]) begin
      c = id[i];
      if ((f == F_BAD_HEAD || f == F_BAD_TAIL) && i == pos) c = bad_char(i == 0);
      msg.push_back(c);
    end
  endfunction

  function automatic void push_body_ident();
    push_ident(rand_ident(body_len()), body_fault);
    body_fault = F_NONE;
  endfunction

  function automatic void push_skip(int n);
    repeat (n) msg.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void push_enum(int maxv);
    logic [7:0] v;
    v = 8'($urandom_range(0, maxv));
    if (enum_fault && enum_seen == enum_pick) v = 8'($urandom_range(maxv + 1, 255));
    enum_seen++;
    msg.push_back(v);
  endfunction

  function automatic void build_request(int tag_sel, bit flag, fault_t f);
    bytes_t     cid;
    bit         on_cmd;
    int         k;
    logic [7:0] c;
    msg.delete();
    if (f == F_BAD_ENUM && tag_sel != 1 && tag_sel != 3) tag_sel = $urandom_range(0, 1) ? 1 : 3;
    if (f == F_BAD_FLAG) tag_sel = 4;
    on_cmd     = (tag_sel == 5) || ($urandom_range(0, 1) == 1);
    body_fault = on_cmd ? F_NONE : f;
    enum_fault = (f == F_BAD_ENUM);
    enum_seen  = 0;
    enum_pick  = $urandom_range(0, 2);
    msg.push_back(f == F_VERSION ? 8'(cur_version + $urandom_range(1, 255)) : cur_version);
    cid = cur_id;
    while (cid.size() > MAX_ID_LEN) void'(cid.pop_back());
    if (cid.size() == 0) cid = rand_ident($urandom_range(1, 4));
    if (f == F_CMD_MISMATCH_BYTE) begin
      k = $urandom_range(0, cid.size() - 1);
      do begin
        c = id_char(k == 0);
      end while (c == cid[k]);
      cid[k] = c;
    end
    if (f == F_CMD_MISMATCH_LEN) begin
      if (cid.size() < MAX_ID_LEN && (cid.size() == 1 || $urandom_range(0, 1) == 1))
        cid.push_back(id_char(1'b0));
      else
        void'(cid.pop_back());
    end
    push_ident(cid, on_cmd ? f : F_NONE);
    if (f == F_BAD_TAG)
      msg.push_back($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(6, 255)));
    else
      msg.push_back(8'(tag_sel));
    case (tag_sel)
      1: begin
        repeat (4) push_body_ident();
        push_enum(1);
        push_skip(8);
        push_enum(2);
        push_skip(8);
        push_enum(2);
        push_skip(8);
      end
      2: begin
        push_body_ident();
        push_skip(4);
        repeat (4) push_body_ident();
      end
      3: begin
        push_body_ident();
        push_skip(4);
        push_enum(1);
        push_skip(8);
        push_enum(2);
        push_skip(8);
        push_enum(2);
        push_skip(8);
        repeat (8) push_body_ident();
      end
      4: begin
        push_body_ident();
        push_skip(4);
        if (f == F_BAD_FLAG) msg.push_back(8'($urandom_range(2, 255)));
        else msg.push_back({7'd0, flag});
        if (flag) repeat (4) push_body_ident();
      end
      default: push_skip(4);
    endcase
    if (f == F_TRUNCATE && msg.size() > 1)
      repeat ($urandom_range(1, msg.size() - 1)) void'(msg.pop_back());
    if (f == F_EXTRA) repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(0, 255)));
    if (f == F_CORRUPT) msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
  endfunction

  function automatic void stage_request();
    item_t it;
    staged.delete();
    foreach (msg[i]) begin
      it.request = 1'b1;
      it.data    = msg[i];
      it.last    = (i == msg.size() - 1);
      staged.push_back(it);
    end
  endfunction

  function automatic void stage_load(bytes_t id);
    item_t it;
    staged.delete();
    foreach (id[i]) begin
      it.request = 1'b0;
      it.data    = id[i];
      it.last    = (i == id.size() - 1);
      staged.push_back(it);
    end
  endfunction

  // Interleave an identifier load with the staged request, possibly split in two.
  function automatic void splice_load(bytes_t id);
    item_t run [$];
    item_t it;
    int    p1;
    int    p2;
    int    k;
    foreach (id[i]) begin
      it.request = 1'b0;
      it.data    = id[i];
      it.last    = (i == id.size() - 1);
      run.push_back(it);
    end
    p1 = $urandom_range(0, staged.size());
    k  = $urandom_range(1, run.size());
    for (int i = 0; i < k; i++) staged.insert(p1 + i, run[i]);
    p2 = $urandom_range(p1 + k, staged.size());
    for (int i = k; i < run.size(); i++) staged.insert(p2 + i - k, run[i]);
  endfunction

  task automatic send_item(input item_t it);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it.data;
    s_tuser  <= it.request;
    s_tlast  <= it.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
    if (it.request && it.last) requests_sent++;
  endtask

  task automatic send_staged();
    foreach (staged[i]) send_item(staged[i]);
  endtask

  task automatic run_request(input int tag_sel, input bit flag, input fault_t f);
    build_request(tag_sel, flag, f);
    stage_request();
    send_staged();
  endtask

  task automatic load_id(input bytes_t id);
    cur_id = id;
    stage_load(id);
    send_staged();
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_version(input logic [7:0] v);
    cur_version = v;
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_transaction();
    int     r;
    fault_t f;
    bytes_t id;
    r = $urandom_range(0, 99);
    if (!last_phase) begin
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
    end
    if (r < 8) begin
      load_id(pick_expected_id());
      return;
    end
    if (r < 16) begin
      msg.delete();
      repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) msg[0] = cur_version;
    end else begin
      f = ($urandom_range(0, 9) < 6) ? F_NONE :
          fault_t'($urandom_range(int'(F_VERSION), int'(F_CORRUPT)));
      build_request($urandom_range(1, 5), $urandom_range(0, 1), f);
    end
    stage_request();
    if (r >= 16 && r < 21) begin
      id = pick_expected_id();
      splice_load(id);
      cur_id = id;
    end
    send_staged();
  endtask

  initial begin
    int base_bytes;
    int base_reqs;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = 8'h00;
    s_tlast       = 1'b0;
    s_tuser       = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = 8'h00;
    cycles        = 0;
    bytes_sent    = 0;
    requests_sent = 0;
    cur_version   = 8'd1;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    last_phase    = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // nothing loaded yet, then a version byte alone
    run_request(5, 1'b0, F_NONE);
    msg.delete();
    msg.push_back(cur_version);
    stage_request();
    send_staged();

    load_id(rand_ident(7));
    for (int t = 1; t <= 5; t++) run_request(t, 1'b0, F_NONE);
    run_request(4, 1'b1, F_NONE);
    for (int k = int'(F_VERSION); k <= int'(F_CORRUPT); k++)
      run_request($urandom_range(1, 5), 1'b1, fault_t'(k));

    // overlong identifier saturates and mismatches, full length one matches
    load_id(rand_ident(MAX_ID_LEN + 2));
    run_request(2, 1'b0, F_NONE);
    load_id(rand_ident(MAX_ID_LEN));
    run_request(5, 1'b0, F_NONE);

    wait_idle();
    write_version(8'd0);
    run_request(1, 1'b0, F_NONE);
    wait_idle();
    write_version(8'd255);
    run_request(3, 1'b0, F_NONE);

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0:       write_version(8'($urandom_range(2, 254)));
        1:       write_version(8'd0);
        2:       write_version(8'd255);
        default: write_version(8'($urandom_range(0, 255)));
      endcase
      if (ph == 3) begin
        last_phase = 1'b1;
        gaps_on    = 1'b0;
        stalls_on  = 1'b0;
      end
      base_bytes = bytes_sent;
      base_reqs  = requests_sent;
      while (bytes_sent - base_bytes < 320 || requests_sent - base_reqs < 15)
        random_transaction();
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/crv_pkg.sv
rtl/crv_ram.sv
rtl/crv_parse.sv
rtl/command_request_validator_top.sv
sim/command_request_validator_top_test.sv
